// ===== rtl/sldf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sldf_pkg - shared types and constants for the sync/length/CRC-8 deframer
// Result record layout, configuration register indexes and reset values.
// ---------------------------------------------------------------------------
package sldf_pkg;

    // Field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned MAXLEN_W  = 11;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned OUT_W     = 40;   // 34 bits of fields, padded to bytes

    // Depth of the queue between parser and output side
    localparam int unsigned QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 2'd2;

    // Configuration reset values
    localparam logic [BYTE_W-1:0]   FIRST_SYNC_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0]   SECOND_SYNC_RST = 8'h55;
    localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST  = 11'd600;

    // Result kinds
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // Frame status codes
    localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

    // Live configuration handed to the parser
    typedef struct packed {
        logic [BYTE_W-1:0]   first_sync;
        logic [BYTE_W-1:0]   second_sync;
        logic [MAXLEN_W-1:0] max_length;
    } cfg_t;

    // One result word as queued between parser and output side
    typedef struct packed {
        logic                item_kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [BYTE_W-1:0]   frame_command;
        logic [LEN_W-1:0]    frame_length;
        logic [STATUS_W-1:0] frame_status;
    } result_t;

endpackage

// ===== rtl/sync_length_crc8_deframer_unit.sv =====
`timescale 1ns / 1ps
// A result word is held in the queue registers before it reaches m_tvalid.
// Throughput: one byte per cycle unless the queue is full; the parser's
// phase step and byte-wide CRC-8 update set it; the queue absorbs stalls.
// Reset (rst_n, asynchronous): parser waits for first sync, queue empties,
// registers take 0xAA, 0x55 and 600.
// ---------------------------------------------------------------------------
// sync_length_crc8_deframer_unit - sync/length framed byte stream deframer
// Finds two sync bytes, decodes command and length, streams payload and
// reports frame status after the CRC-8 trailer, or at once on an oversize length.
// ---------------------------------------------------------------------------
module sync_length_crc8_deframer_unit
#(
    parameter int unsigned QUEUE_DEPTH = sldf_pkg::QUEUE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] payload_byte, [15:8] frame_command, [31:16] frame_length,
    // [33:32] frame_status, [39:34] zero
    output logic [sldf_pkg::OUT_W-1:0]     m_tdata,
    output logic                           m_tuser,   // [0] item_kind
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sldf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sldf_pkg::MAXLEN_W-1:0]  cfg_data
);

    sldf_pkg::cfg_t    cfg_reg;
    sldf_pkg::result_t res_word;
    sldf_pkg::result_t head_word;
    logic              res_valid;
    logic              queue_full;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_sync  <= sldf_pkg::FIRST_SYNC_RST;
            cfg_reg.second_sync <= sldf_pkg::SECOND_SYNC_RST;
            cfg_reg.max_length  <= sldf_pkg::MAX_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sldf_pkg::REG_FIRST_SYNC:  cfg_reg.first_sync  <= cfg_data[7:0];
                sldf_pkg::REG_SECOND_SYNC: cfg_reg.second_sync <= cfg_data[7:0];
                sldf_pkg::REG_MAX_LENGTH:  cfg_reg.max_length  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Front end
    sldf_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_ready   (s_tready),
        .queue_full (queue_full),
        .res_valid  (res_valid),
        .res        (res_word)
    );

    // Queue and output side
    sldf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_word (res_word),
        .full      (queue_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (head_word)
    );

    // Output word packing
    assign m_tuser = head_word.item_kind;
    assign m_tdata = {6'd0, head_word.frame_status, head_word.frame_length,
                      head_word.frame_command, head_word.payload_byte};

endmodule

// ===== rtl/sldf_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sldf_parser - front end: sync hunt, header decode, CRC-8 and classification
// Takes one byte a cycle unless queue_full; queues at most one result word.
// ---------------------------------------------------------------------------
module sldf_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sldf_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    output logic                  in_ready,
    input  logic                  queue_full,
    output logic                  res_valid,
    output sldf_pkg::result_t     res
);

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_CMD     = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CRC     = 3'd6
    } phase_t;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Reflected CRC-8, one byte, LSB first
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       low;
        c = crc;
        d = data;
        for (int i = 0; i < 8; i++)
        begin
            low = c[0] ^ d[0];
            c   = {1'b0, c[7:1]};
            if (low)
                c = c ^ CRC_POLY;
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

    phase_t      phase_reg,   phase_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] length_reg,  length_next;
    logic [15:0] count_reg,   count_next;
    logic [7:0]  crc_reg,     crc_next;

    logic        accept;
    logic [7:0]  crc_upd;
    logic [15:0] new_length;
    logic [15:0] count_inc;

    assign in_ready   = !queue_full;
    assign accept     = in_valid && in_ready;
    assign crc_upd    = crc_feed((phase_reg == PH_CMD) ? 8'h00 : crc_reg, in_byte);
    assign new_length = {length_reg[15:8], in_byte};
    assign count_inc  = count_reg + 16'd1;

    // Next state and result word
    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        res_valid    = 1'b0;
        res.item_kind     = sldf_pkg::KIND_PAYLOAD;
        res.payload_byte  = 8'h00;
        res.frame_command = command_reg;
        res.frame_length  = length_reg;
        res.frame_status  = sldf_pkg::STATUS_GOOD;
        if (accept)
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    phase_next = (in_byte == cfg.second_sync) ? PH_CMD : PH_SYNC1;
                end
                PH_CMD:
                begin
                    command_next = in_byte;
                    crc_next     = crc_upd;
                    phase_next   = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    length_next = {in_byte, 8'h00};
                    crc_next    = crc_upd;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = new_length;
                    crc_next    = crc_upd;
                    count_next  = 16'd0;
                    if (new_length > {5'd0, cfg.max_length})
                    begin
                        // oversize header ends the frame straight away
                        phase_next       = PH_SYNC1;
                        res_valid        = 1'b1;
                        res.item_kind    = sldf_pkg::KIND_FRAME_END;
                        res.frame_length = new_length;
                        res.frame_status = sldf_pkg::STATUS_TOO_LONG;
                    end
                    else
                    begin
                        phase_next = (new_length != 16'd0) ? PH_PAYLOAD : PH_CRC;
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next   = crc_upd;
                    count_next = count_inc;
                    if (count_inc >= length_reg)
                        phase_next = PH_CRC;
                    res_valid        = 1'b1;
                    res.payload_byte = in_byte;
                end
                PH_CRC:
                begin
                    phase_next       = PH_SYNC1;
                    res_valid        = 1'b1;
                    res.item_kind    = sldf_pkg::KIND_FRAME_END;
                    res.frame_status = (in_byte == crc_reg) ? sldf_pkg::STATUS_GOOD
                                                            : sldf_pkg::STATUS_CRC_BAD;
                end
                default:
                begin
                    phase_next = (in_byte == cfg.first_sync) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC1;
            command_reg <= 8'h00;
            length_reg  <= 16'h0000;
            count_reg   <= 16'h0000;
            crc_reg     <= 8'h00;
        end
        else
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
        end
    end

endmodule

// ===== rtl/sldf_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sldf_queue - result queue and output side
// Small register FIFO; the head word drives the master stream directly.
// ---------------------------------------------------------------------------
module sldf_queue
#(
    parameter int unsigned DEPTH = sldf_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sldf_pkg::result_t push_word,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output sldf_pkg::result_t out_word
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sldf_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    assign full      = (count_reg == FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_word  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_word;
    end

endmodule

// ===== rtl/sldf_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sldf_checker - port-level checks for the deframer
// Watches the output stream and configuration handshake.
// ---------------------------------------------------------------------------
module sldf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_ready
);

    // A stalled word is not withdrawn
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word withdrawn under stall");

    // Status code three is never produced
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[33:32] != 2'd3))
        else $error("illegal frame status");

    // Payload words carry good status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[33:32] == 2'd0))
        else $error("payload word with nonzero status");

    // Frame-end words carry a zero data byte and zero padding
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[7:0] == 8'd0) && (m_tdata[39:34] == 6'd0))
        else $error("frame-end word with data byte set");

    // Configuration is always writable
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind sync_length_crc8_deframer_unit sldf_checker u_sldf_checker (.*);
